FILE: src/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// No dependencies; used by sle_cell and sequential_list_engine_core.
package sle_pkg;

   localparam int DATA_W   = 32;
   localparam int CAPACITY = 64;
   localparam int MAX_LW   = 11;   // holds a length up to 1024

   typedef enum logic [2:0] {
      OP_FIND          = 3'd0,
      OP_INSERT_AT     = 3'd1,
      OP_DELETE_AT     = 3'd2,
      OP_MODIFY_AT     = 3'd3,
      OP_SORT          = 3'd4,
      OP_INSERT_SORTED = 3'd5,
      OP_DUMP          = 3'd6,
      OP_CLEAR         = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_WRITE,
      CM_SHIFT_R,
      CM_SHIFT_L,
      CM_ROTATE,
      CM_SORT
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_PLACE,
      ST_SORT,
      ST_DUMP,
      ST_REPLY
   } state_type;

   typedef struct packed {
      cell_mode_type            mode;
      logic [MAX_LW-1:0]        pos;     // 0-based target index
      logic [MAX_LW-1:0]        len;     // current list length
      logic                     parity;  // sort pair phase
      logic signed [DATA_W-1:0] val;     // broadcast value
   } cell_ctrl_type;

endpackage

FILE: src/sle_cell.sv
// One list slot: holds an entry, moves data to/from its neighbors.
// Depends on sle_pkg.
module sle_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  sle_pkg::cell_ctrl_type           ctrl,
   input  logic signed [sle_pkg::DATA_W-1:0] left_value,
   input  logic signed [sle_pkg::DATA_W-1:0] right_value,
   output logic signed [sle_pkg::DATA_W-1:0] value,
   output logic                             eq,
   output logic                             le
);

   localparam logic [sle_pkg::MAX_LW-1:0] IDX      = sle_pkg::MAX_LW'(INDEX);
   localparam logic [sle_pkg::MAX_LW-1:0] IDX_NEXT = sle_pkg::MAX_LW'(INDEX + 1);

   logic signed [sle_pkg::DATA_W-1:0] entry_ff;
   logic signed [sle_pkg::DATA_W-1:0] entry_in;
   logic                              live;

   assign value = entry_ff;
   assign live  = ctrl.len > IDX;
   assign eq    = live && (entry_ff == ctrl.val);
   assign le    = live && (entry_ff <= ctrl.val);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.mode)
         sle_pkg::CM_WRITE: begin
            if (IDX == ctrl.pos) entry_in = ctrl.val;
         end
         sle_pkg::CM_SHIFT_R: begin
            if (IDX == ctrl.pos) entry_in = ctrl.val;
            else if (IDX > ctrl.pos) entry_in = left_value;
         end
         sle_pkg::CM_SHIFT_L: begin
            if (IDX >= ctrl.pos) entry_in = right_value;
         end
         sle_pkg::CM_ROTATE: begin
            if (ctrl.len > IDX_NEXT) entry_in = right_value;
            else if (ctrl.len == IDX_NEXT) entry_in = ctrl.val;
         end
         sle_pkg::CM_SORT: begin
            // lower slot of a pair takes the smaller, upper the larger
            if (IDX[0] == ctrl.parity) begin
               if (ctrl.len > IDX_NEXT && entry_ff > right_value) entry_in = right_value;
            end else begin
               if (INDEX >= 1 && live && left_value > entry_ff) entry_in = left_value;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: src/sequential_list_engine_core.sv
// Top level of the sequential list engine: control sequencer and the
// chain of sle_cell slots. Depends on sle_pkg and sle_cell.
//  - Request channel (req_valid/req_ready): op, position, value. One
//    transaction per operation.
//  - Response channel (rsp_valid/rsp_ready): status, found_position,
//    element, list_length, last. One response transaction per op, except
//    a dump of a non-empty list: one per entry, last set on the final one.
//  - Sequencing: insert_at, delete_at, modify_at, clear, a full
//    insert_sorted and a short sort reply straight from acceptance;
//    find registers a compare pass, then priority encodes; insert_sorted
//    compares, shifts, then replies; sort runs length odd-even passes,
//    then replies; dump gives one entry per cycle while rsp_ready holds.
//  - One operation in flight; a new request is taken once the engine is
//    idle and the response register is free or draining, so ops that reply
//    straight from acceptance run back to back while the receiver keeps up.
//  - Reset empties the list. Slot contents are not cleared; only slots
//    below the length are ever read.
//  - A stalled receiver holds the response register; the engine waits.
module sequential_list_engine_core #(
   parameter int CAPACITY = sle_pkg::CAPACITY,
   localparam int LW = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_op,
   input  logic [LW-1:0]                     req_position,
   input  logic signed [sle_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_status,
   output logic [LW-1:0]                     rsp_found_position,
   output logic signed [sle_pkg::DATA_W-1:0] rsp_element,
   output logic [LW-1:0]                     rsp_list_length,
   output logic                              rsp_last
);

   localparam logic [LW:0] CAP_X = (LW + 1)'(CAPACITY);

   sle_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic               par_ff, par_in;
   logic signed [sle_pkg::DATA_W-1:0] val_ff, val_in;
   logic [CAPACITY-1:0] match_ff, match_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              status_ff, status_in;
   logic [LW-1:0]                     fpos_ff, fpos_in;
   logic signed [sle_pkg::DATA_W-1:0] elem_ff, elem_in;
   logic [LW-1:0]                     rlen_ff, rlen_in;
   logic                              last_ff, last_in;

   sle_pkg::cell_ctrl_type ctrl;
   logic signed [sle_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0] eq_vec, le_vec;

   logic          slot_free;
   logic          accept;
   logic [LW-1:0] low_pos;   // first match, 1-based
   logic [LW-1:0] ins_pos;   // 0-based slot for sorted insert
   logic [LW-1:0] pos_m1;

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sle_pkg::DATA_W-1:0] lv, rv;
      if (i == 0) begin : g_l0
         assign lv = '0;
      end else begin : g_l
         assign lv = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_rn
         assign rv = '0;
      end else begin : g_r
         assign rv = cell_value[i+1];
      end
      sle_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_value (lv),
         .right_value(rv),
         .value      (cell_value[i]),
         .eq         (eq_vec[i]),
         .le         (le_vec[i])
      );
   end

   // ---------------- priority encoders ----------------
   always_comb begin
      low_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) low_pos = LW'(i + 1);
      end
   end

   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_ff[i]) ins_pos = LW'(i + 1);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == sle_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign pos_m1    = req_position - LW'(1);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      par_in   = par_ff;
      val_in   = val_ff;
      match_in = match_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      fpos_in      = fpos_ff;
      elem_in      = elem_ff;
      rlen_in      = rlen_ff;
      last_in      = last_ff;

      ctrl        = '0;
      ctrl.mode   = sle_pkg::CM_HOLD;
      ctrl.len    = sle_pkg::MAX_LW'(len_ff);
      ctrl.parity = par_ff;
      ctrl.val    = (state_ff == sle_pkg::ST_IDLE) ? req_value : val_ff;

      case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (accept) begin
               val_in       = req_value;
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               fpos_in      = '0;
               elem_in      = '0;
               last_in      = 1'b1;
               rlen_in      = len_ff;
               case (sle_pkg::op_type'(req_op))
                  sle_pkg::OP_FIND: begin
                     rsp_valid_in = 1'b0;
                     match_in     = eq_vec;
                     state_in     = sle_pkg::ST_FIND;
                  end
                  sle_pkg::OP_INSERT_AT: begin
                     if ({1'b0, len_ff} >= CAP_X || req_position == '0 ||
                         {1'b0, req_position} > {1'b0, len_ff} + (LW + 1)'(1)) begin
                        status_in = 1'b1;
                     end else begin
                        ctrl.mode = sle_pkg::CM_SHIFT_R;
                        ctrl.pos  = sle_pkg::MAX_LW'(pos_m1);
                        len_in    = len_ff + LW'(1);
                        rlen_in   = len_ff + LW'(1);
                     end
                  end
                  sle_pkg::OP_DELETE_AT: begin
                     if (req_position == '0 || req_position > len_ff) begin
                        status_in = 1'b1;
                     end else begin
                        ctrl.mode = sle_pkg::CM_SHIFT_L;
                        ctrl.pos  = sle_pkg::MAX_LW'(pos_m1);
                        len_in    = len_ff - LW'(1);
                        rlen_in   = len_ff - LW'(1);
                     end
                  end
                  sle_pkg::OP_MODIFY_AT: begin
                     if (req_position == '0 || req_position > len_ff) begin
                        status_in = 1'b1;
                     end else begin
                        ctrl.mode = sle_pkg::CM_WRITE;
                        ctrl.pos  = sle_pkg::MAX_LW'(pos_m1);
                     end
                  end
                  sle_pkg::OP_SORT: begin
                     if (len_ff > LW'(1)) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = len_ff;
                        par_in       = 1'b0;
                        state_in     = sle_pkg::ST_SORT;
                     end
                  end
                  sle_pkg::OP_INSERT_SORTED: begin
                     if ({1'b0, len_ff} >= CAP_X) begin
                        status_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        match_in     = le_vec;
                        state_in     = sle_pkg::ST_PLACE;
                     end
                  end
                  sle_pkg::OP_DUMP: begin
                     if (len_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = len_ff;
                        state_in     = sle_pkg::ST_DUMP;
                     end
                  end
                  sle_pkg::OP_CLEAR: begin
                     len_in  = '0;
                     rlen_in = '0;
                  end
                  default: status_in = 1'b1;
               endcase
            end
         end

         sle_pkg::ST_FIND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ~(|match_ff);
               fpos_in      = low_pos;
               elem_in      = '0;
               rlen_in      = len_ff;
               last_in      = 1'b1;
               state_in     = sle_pkg::ST_IDLE;
            end
         end

         sle_pkg::ST_PLACE: begin
            // behind the last entry not greater than the value
            ctrl.mode = sle_pkg::CM_SHIFT_R;
            ctrl.pos  = sle_pkg::MAX_LW'(ins_pos);
            len_in    = len_ff + LW'(1);
            state_in  = sle_pkg::ST_REPLY;
         end

         sle_pkg::ST_SORT: begin
            ctrl.mode = sle_pkg::CM_SORT;
            par_in    = ~par_ff;
            cnt_in    = cnt_ff - LW'(1);
            if (cnt_ff == LW'(1)) state_in = sle_pkg::ST_REPLY;
         end

         sle_pkg::ST_DUMP: begin
            if (slot_free) begin
               ctrl.mode    = sle_pkg::CM_ROTATE;
               ctrl.val     = cell_value[0];
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               fpos_in      = '0;
               elem_in      = cell_value[0];
               rlen_in      = len_ff;
               last_in      = (cnt_ff == LW'(1));
               cnt_in       = cnt_ff - LW'(1);
               if (cnt_ff == LW'(1)) state_in = sle_pkg::ST_IDLE;
            end
         end

         sle_pkg::ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               fpos_in      = '0;
               elem_in      = '0;
               rlen_in      = len_ff;
               last_in      = 1'b1;
               state_in     = sle_pkg::ST_IDLE;
            end
         end

         default: state_in = sle_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      par_ff    <= par_in;
      val_ff    <= val_in;
      match_ff  <= match_in;
      status_ff <= status_in;
      fpos_ff   <= fpos_in;
      elem_ff   <= elem_in;
      rlen_ff   <= rlen_in;
      last_ff   <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_element        = elem_ff;
   assign rsp_list_length    = rlen_ff;
   assign rsp_last           = last_ff;

endmodule

FILE: dv/sequential_list_engine_core_test.sv
// Self-checking testbench for sequential_list_engine_core.
// Depends on sle_pkg and the engine RTL; holds its own list predictor.
module sequential_list_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 600000;

   typedef struct {
      logic                     status;
      logic [6:0]               found_position;
      logic signed [31:0]       element;
      logic [6:0]               list_length;
      logic                     last;
   } list_reply_type;

   // Predicts replies from a private copy of the list and checks them in order.
   class list_scoreboard;
      logic signed [31:0] slots[sle_pkg::CAPACITY];
      int                 count;
      list_reply_type     replies[$];
      int                 mismatches;

      function new();
         count = 0;
         mismatches = 0;
      endfunction

      function void push(logic st, logic [6:0] fp, logic signed [31:0] el, logic lst);
         list_reply_type r;
         r.status = st;
         r.found_position = fp;
         r.element = el;
         r.list_length = count[6:0];
         r.last = lst;
         replies.push_back(r);
      endfunction

      function void note_request(sle_pkg::op_type op, logic [6:0] pos,
                                 logic signed [31:0] v);
         int i;
         int hit;
         logic signed [31:0] key;
         case (op)
            sle_pkg::OP_FIND: begin
               hit = 0;
               for (i = 0; i < count; i++)
                  if (hit == 0 && slots[i] == v) hit = i + 1;
               push(hit == 0, hit[6:0], 0, 1'b1);
            end
            sle_pkg::OP_INSERT_AT: begin
               if (count >= sle_pkg::CAPACITY || pos < 1 || pos > count + 1) begin
                  push(1'b1, 0, 0, 1'b1);
               end else begin
                  for (i = count; i > pos - 1; i--) slots[i] = slots[i-1];
                  slots[pos-1] = v;
                  count++;
                  push(1'b0, 0, 0, 1'b1);
               end
            end
            sle_pkg::OP_DELETE_AT: begin
               if (pos < 1 || pos > count) begin
                  push(1'b1, 0, 0, 1'b1);
               end else begin
                  for (i = pos - 1; i + 1 < count; i++) slots[i] = slots[i+1];
                  count--;
                  push(1'b0, 0, 0, 1'b1);
               end
            end
            sle_pkg::OP_MODIFY_AT: begin
               if (pos < 1 || pos > count) begin
                  push(1'b1, 0, 0, 1'b1);
               end else begin
                  slots[pos-1] = v;
                  push(1'b0, 0, 0, 1'b1);
               end
            end
            sle_pkg::OP_SORT: begin
               // stable insertion sort, signed compare
               for (i = 1; i < count; i++) begin
                  key = slots[i];
                  hit = i;
                  while (hit > 0 && key < slots[hit-1]) begin
                     slots[hit] = slots[hit-1];
                     hit--;
                  end
                  slots[hit] = key;
               end
               push(1'b0, 0, 0, 1'b1);
            end
            sle_pkg::OP_INSERT_SORTED: begin
               if (count >= sle_pkg::CAPACITY) begin
                  push(1'b1, 0, 0, 1'b1);
               end else begin
                  i = count;
                  while (i > 0 && v < slots[i-1]) begin
                     slots[i] = slots[i-1];
                     i--;
                  end
                  slots[i] = v;
                  count++;
                  push(1'b0, 0, 0, 1'b1);
               end
            end
            sle_pkg::OP_DUMP: begin
               if (count == 0) push(1'b0, 0, 0, 1'b1);
               for (i = 0; i < count; i++) push(1'b0, 0, slots[i], i + 1 == count);
            end
            default: begin
               count = 0;
               push(1'b0, 0, 0, 1'b1);
            end
         endcase
      endfunction

      function void check_reply(list_reply_type got);
         list_reply_type want;
         if (replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d fpos %0d elem %0d len %0d last %0d",
                        got.status, got.found_position, got.element, got.list_length,
                        got.last);
            return;
         end
         want = replies.pop_front();
         if (got.status !== want.status || got.found_position !== want.found_position ||
             got.element !== want.element || got.list_length !== want.list_length ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp st %0d fp %0d el %0d len %0d last %0d,",
                         " got st %0d fp %0d el %0d len %0d last %0d"},
                        want.status, want.found_position, want.element, want.list_length,
                        want.last, got.status, got.found_position, got.element,
                        got.list_length, got.last);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_op;
   logic [6:0]        req_position;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_status;
   logic [6:0]        rsp_found_position;
   logic signed [31:0] rsp_element;
   logic [6:0]        rsp_list_length;
   logic              rsp_last;

   list_scoreboard    board;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                cycles;
   logic signed [31:0] value_pool[8];

   sequential_list_engine_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_position(req_position), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_found_position(rsp_found_position),
      .rsp_element(rsp_element), .rsp_list_length(rsp_list_length),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Reads at the edge see pre-edge values, since all drivers use NBAs.
   always @(posedge clock) begin
      list_reply_type got;
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && req_valid && req_ready)
         board.note_request(sle_pkg::op_type'(req_op), req_position, req_value);
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.found_position = rsp_found_position;
         got.element = rsp_element;
         got.list_length = rsp_list_length;
         got.last = rsp_last;
         board.check_reply(got);
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request transaction; valid stays high across back-to-back items.
   task automatic send(sle_pkg::op_type op, int pos, logic signed [31:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_position <= pos[6:0];
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return $urandom;
         default: return value_pool[$urandom_range(7)];
      endcase
   endfunction

   task automatic random_items(int n);
      int k;
      int len;
      int pos;
      sle_pkg::op_type op;
      for (k = 0; k < n; k++) begin
         len = board.count;
         op = sle_pkg::op_type'($urandom_range(7));
         // clear and dump less often so the list grows deep
         if ((op == sle_pkg::OP_CLEAR && $urandom_range(5) != 0) ||
             (op == sle_pkg::OP_DUMP && $urandom_range(2) != 0))
            op = ($urandom_range(1) != 0) ? sle_pkg::OP_INSERT_SORTED : sle_pkg::OP_INSERT_AT;
         if ($urandom_range(9) == 0) pos = $urandom_range(65);
         else if (op == sle_pkg::OP_INSERT_AT) pos = $urandom_range(len + 1, 1);
         else pos = (len == 0) ? 1 : $urandom_range(len, 1);
         send(op, pos, pick_value());
         if ($urandom_range(39) == 0) drain();
      end
   endtask

   initial begin
      int k;
      board = new();
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = sle_pkg::OP_FIND;
      req_position = '0;
      req_value = '0;
      rsp_ready = 1'b0;
      for (k = 0; k < 8; k++) value_pool[k] = $urandom_range(20) - 10;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, bad positions, extremes, duplicates.
      send_idle_pct = 8;
      recv_stall_pct = 69;
      send(sle_pkg::OP_DUMP, 0, 0);
      send(sle_pkg::OP_FIND, 0, 0);
      send(sle_pkg::OP_DELETE_AT, 1, 0);
      send(sle_pkg::OP_MODIFY_AT, 1, 5);
      send(sle_pkg::OP_INSERT_AT, 0, 1);
      send(sle_pkg::OP_INSERT_AT, 2, 1);
      send(sle_pkg::OP_INSERT_AT, 1, 32'sh7fffffff);
      send(sle_pkg::OP_INSERT_AT, 1, 32'sh80000000);
      send(sle_pkg::OP_INSERT_AT, 3, 0);
      send(sle_pkg::OP_INSERT_SORTED, 0, -5);
      send(sle_pkg::OP_INSERT_SORTED, 0, 0);
      send(sle_pkg::OP_FIND, 0, 32'sh80000000);
      send(sle_pkg::OP_FIND, 0, 0);
      send(sle_pkg::OP_FIND, 0, 12345);
      send(sle_pkg::OP_MODIFY_AT, 2, -1);
      send(sle_pkg::OP_MODIFY_AT, 6, 3);
      send(sle_pkg::OP_INSERT_AT, 65, 3);
      send(sle_pkg::OP_SORT, 0, 0);
      send(sle_pkg::OP_DUMP, 0, 0);
      send(sle_pkg::OP_DELETE_AT, 5, 0);
      send(sle_pkg::OP_DELETE_AT, 1, 0);
      send(sle_pkg::OP_DELETE_AT, 0, 0);
      drain();

      // Fill to capacity, then the full-list cases.
      while (board.count < sle_pkg::CAPACITY)
         send(sle_pkg::OP_INSERT_SORTED, 0, pick_value());
      send(sle_pkg::OP_INSERT_AT, 1, 7);
      send(sle_pkg::OP_INSERT_SORTED, 0, 7);
      send(sle_pkg::OP_MODIFY_AT, 64, 32'sh80000000);
      send(sle_pkg::OP_SORT, 0, 0);
      send(sle_pkg::OP_DUMP, 0, 0);
      send(sle_pkg::OP_DELETE_AT, 64, 0);
      send(sle_pkg::OP_INSERT_AT, 64, -2);
      send(sle_pkg::OP_CLEAR, 0, 0);
      send(sle_pkg::OP_DUMP, 0, 0);

      random_items(60);
      drain();
      send_idle_pct = 69;
      recv_stall_pct = 8;
      random_items(60);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_items(60);
      drain();
      repeat (80) @(posedge clock);
      if (board.mismatches == 0 && board.replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
